>>> hdl/nvm_slot_image_validator_core_defines.svh
// assertion macros used by the validator check stage
`ifndef NVM_SLOT_IMAGE_VALIDATOR_CORE_DEFINES_SVH
`define NVM_SLOT_IMAGE_VALIDATOR_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define NVM_SVI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NVM_SVI_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define NVM_SVI_ASSERT(lbl, prop, msg)
`define NVM_SVI_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

>>> hdl/nvm_svi_pkg.sv
`timescale 1ns / 1ps

package nvm_svi_pkg;

    localparam int PAYLOAD_BYTES = 120;
    localparam int HEADER_BYTES  = 12;

    localparam logic [7:0]  SLOT_BYTES    = 8'(HEADER_BYTES + PAYLOAD_BYTES);
    localparam logic [7:0]  HDR_END       = 8'(HEADER_BYTES);
    localparam logic [15:0] PAYLOAD_LEN   = 16'(PAYLOAD_BYTES);
    localparam logic [7:0]  POS_MAGIC_END = 8'd4;
    localparam logic [7:0]  POS_VER_LO    = 8'd4;
    localparam logic [7:0]  POS_VER_HI    = 8'd5;
    localparam logic [7:0]  POS_SEQ_LO    = 8'd6;
    localparam logic [7:0]  POS_SEQ_HI    = 8'd7;
    localparam logic [7:0]  POS_CRC_LO    = 8'd8;
    localparam logic [7:0]  POS_CRC_HI    = 8'd9;
    localparam logic [7:0]  POS_LEN_LO    = 8'd10;
    localparam logic [7:0]  POS_LEN_HI    = 8'd11;
    localparam logic [7:0]  POS_MAX       = 8'hFF;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] SEQ_HALF = 16'h8000;

    localparam logic [7:0]  RST_SLOT_COUNT = 8'd2;
    localparam logic [31:0] RST_MAGIC      = 32'd0;
    localparam logic [15:0] RST_VERSION    = 16'd3;

    typedef enum logic [1:0] {
        CMD_BYTE   = 2'd0,
        CMD_UNREAD = 2'd1,
        CMD_SCAN   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_SLOT_COUNT = 2'd0,
        CFG_MAGIC      = 2'd1,
        CFG_VERSION    = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        RSN_OK         = 3'd0,
        RSN_UNREADABLE = 3'd1,
        RSN_MAGIC      = 3'd2,
        RSN_VERSION    = 3'd3,
        RSN_LENGTH     = 3'd4,
        RSN_CRC        = 3'd5,
        RSN_COUNT      = 3'd6,
        RSN_BEYOND     = 3'd7
    } reason_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
        logic       last_in_slot;
    } item_t;

    typedef struct packed {
        logic [15:0] next_sequence;
        logic [7:0]  next_write_slot;
        logic [15:0] best_sequence;
        logic [7:0]  best_slot;
        logic        best_found;
        logic [15:0] slot_sequence;
        logic [2:0]  reject_reason;
        logic        slot_valid;
        logic [7:0]  slot_index;
    } result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic seq_newer(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] d;
        d = a - b;
        return (d != 16'd0) && (d < SEQ_HALF);
    endfunction

endpackage

>>> hdl/nvm_svi_in_stage.sv
`timescale 1ns / 1ps

module nvm_svi_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  nvm_svi_pkg::item_t  in_item,
    input  logic                take,
    output logic                item_valid,
    output nvm_svi_pkg::item_t  item
);
    import nvm_svi_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    assign in_ready   = !valid_reg || take;
    assign accept     = in_valid && in_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_item;
    end

endmodule

>>> hdl/nvm_svi_check.sv
`timescale 1ns / 1ps
`include "nvm_slot_image_validator_core_defines.svh"

module nvm_svi_check
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic                  go,
    input  nvm_svi_pkg::item_t    item,
    output logic                  busy,
    output logic                  res_fire,
    output nvm_svi_pkg::result_t  res
);
    import nvm_svi_pkg::*;

    logic [7:0]  slot_count_reg;
    logic [31:0] magic_word_reg;
    logic [15:0] format_version_reg;

    logic [7:0]  byte_position_reg,   byte_position_next;
    logic [15:0] running_crc_reg,     running_crc_next;
    logic        magic_match_reg,     magic_match_next;
    logic [15:0] header_version_reg,  header_version_next;
    logic [15:0] header_sequence_reg, header_sequence_next;
    logic [15:0] header_crc_reg,      header_crc_next;
    logic [15:0] header_length_reg,   header_length_next;
    logic [7:0]  current_slot_reg,    current_slot_next;
    logic        have_best_reg,       have_best_next;
    logic [7:0]  newest_slot_reg,     newest_slot_next;
    logic [15:0] newest_sequence_reg, newest_sequence_next;

    logic        rem_busy_reg,        rem_busy_next;
    logic [2:0]  rem_step_reg,        rem_step_next;
    logic [8:0]  rem_acc_reg,         rem_acc_next;
    logic [7:0]  rem_num_reg,         rem_num_next;
    logic [7:0]  next_slot_reg,       next_slot_next;

    logic [7:0]  pos;
    logic [7:0]  b;
    logic        tk_magic;
    logic [15:0] tk_ver;
    logic [15:0] tk_seq;
    logic [15:0] tk_crc;
    logic [15:0] tk_len;
    logic [15:0] tk_run;
    logic [7:0]  tk_pos;
    logic        beyond;
    reason_t     end_reason;
    logic        best_upd;
    logic [7:0]  cur_inc;
    logic [7:0]  fresh_next_slot;
    logic [8:0]  rem_shift;
    logic [8:0]  rem_trial;

    assign pos    = byte_position_reg;
    assign b      = item.data_byte;
    assign beyond = current_slot_reg >= slot_count_reg;
    assign cur_inc = (current_slot_reg == POS_MAX) ? current_slot_reg : current_slot_reg + 8'd1;
    // fresh best sits below slot_count, so one compare replaces the remainder
    assign fresh_next_slot = (cur_inc == slot_count_reg) ? 8'd0 : cur_inc;
    assign busy = rem_busy_reg;

    // restoring remainder of newest slot plus one by slot_count, one bit per cycle
    assign rem_shift = {rem_acc_reg[7:0], rem_num_reg[rem_step_reg]};
    assign rem_trial = (rem_shift >= {1'b0, slot_count_reg}) ?
                       rem_shift - {1'b0, slot_count_reg} : rem_shift;

    always_comb
    begin
        rem_busy_next  = rem_busy_reg;
        rem_step_next  = rem_step_reg;
        rem_acc_next   = rem_acc_reg;
        rem_num_next   = rem_num_reg;
        next_slot_next = next_slot_reg;
        if (cfg_we && cfg_index == CFG_SLOT_COUNT)
        begin
            rem_busy_next = 1'b1;
            rem_step_next = 3'd7;
            rem_acc_next  = 9'd0;
            rem_num_next  = newest_slot_reg + 8'd1;
        end
        else if (rem_busy_reg)
        begin
            rem_acc_next = rem_trial;
            if (rem_step_reg == 3'd0)
            begin
                rem_busy_next  = 1'b0;
                next_slot_next = rem_trial[7:0];
            end
            else
                rem_step_next = rem_step_reg - 3'd1;
        end
        else if (best_upd)
            next_slot_next = fresh_next_slot;
    end

    // header capture and payload crc for the incoming byte
    always_comb
    begin
        tk_magic = magic_match_reg;
        tk_ver   = header_version_reg;
        tk_seq   = header_sequence_reg;
        tk_crc   = header_crc_reg;
        tk_len   = header_length_reg;
        tk_run   = running_crc_reg;
        if (pos < POS_MAGIC_END)
        begin
            if (magic_word_reg[{pos[1:0], 3'b000} +: 8] != b)
                tk_magic = 1'b0;
        end
        else if (pos == POS_VER_LO)
            tk_ver[7:0] = tk_ver[7:0] | b;
        else if (pos == POS_VER_HI)
            tk_ver[15:8] = tk_ver[15:8] | b;
        else if (pos == POS_SEQ_LO)
            tk_seq[7:0] = tk_seq[7:0] | b;
        else if (pos == POS_SEQ_HI)
            tk_seq[15:8] = tk_seq[15:8] | b;
        else if (pos == POS_CRC_LO)
            tk_crc[7:0] = tk_crc[7:0] | b;
        else if (pos == POS_CRC_HI)
            tk_crc[15:8] = tk_crc[15:8] | b;
        else if (pos == POS_LEN_LO)
            tk_len[7:0] = tk_len[7:0] | b;
        else if (pos == POS_LEN_HI)
            tk_len[15:8] = tk_len[15:8] | b;
        else if (pos >= HDR_END && pos < SLOT_BYTES)
            tk_run = crc_byte(running_crc_reg, b);
        tk_pos = (pos == POS_MAX) ? pos : pos + 8'd1;
    end

    always_comb
    begin
        if (beyond)
            end_reason = RSN_BEYOND;
        else if (!tk_magic)
            end_reason = RSN_MAGIC;
        else if (tk_ver != format_version_reg)
            end_reason = RSN_VERSION;
        else if (tk_len != PAYLOAD_LEN)
            end_reason = RSN_LENGTH;
        else if (tk_crc != tk_run)
            end_reason = RSN_CRC;
        else if (tk_pos != SLOT_BYTES)
            end_reason = RSN_COUNT;
        else
            end_reason = RSN_OK;
    end

    always_comb
    begin
        byte_position_next   = byte_position_reg;
        running_crc_next     = running_crc_reg;
        magic_match_next     = magic_match_reg;
        header_version_next  = header_version_reg;
        header_sequence_next = header_sequence_reg;
        header_crc_next      = header_crc_reg;
        header_length_next   = header_length_reg;
        current_slot_next    = current_slot_reg;
        have_best_next       = have_best_reg;
        newest_slot_next     = newest_slot_reg;
        newest_sequence_next = newest_sequence_reg;
        res_fire             = 1'b0;
        best_upd             = 1'b0;
        res.slot_index       = current_slot_reg;
        res.reject_reason    = RSN_OK;
        res.slot_sequence    = 16'd0;

        if (go)
        begin
            case (item.cmd)
                CMD_SCAN:
                begin
                    byte_position_next   = 8'd0;
                    running_crc_next     = CRC_INIT;
                    magic_match_next     = 1'b1;
                    header_version_next  = 16'd0;
                    header_sequence_next = 16'd0;
                    header_crc_next      = 16'd0;
                    header_length_next   = 16'd0;
                    current_slot_next    = 8'd0;
                    have_best_next       = 1'b0;
                    newest_slot_next     = 8'd0;
                    newest_sequence_next = 16'd0;
                end
                CMD_UNREAD:
                begin
                    res_fire             = 1'b1;
                    res.reject_reason    = beyond ? RSN_BEYOND : RSN_UNREADABLE;
                    byte_position_next   = 8'd0;
                    running_crc_next     = CRC_INIT;
                    magic_match_next     = 1'b1;
                    header_version_next  = 16'd0;
                    header_sequence_next = 16'd0;
                    header_crc_next      = 16'd0;
                    header_length_next   = 16'd0;
                    current_slot_next    = cur_inc;
                end
                CMD_BYTE:
                begin
                    if (item.last_in_slot)
                    begin
                        res_fire          = 1'b1;
                        res.reject_reason = end_reason;
                        res.slot_sequence = tk_seq;
                        best_upd = (end_reason == RSN_OK) &&
                                   (!have_best_reg || seq_newer(tk_seq, newest_sequence_reg));
                        if (best_upd)
                        begin
                            have_best_next       = 1'b1;
                            newest_slot_next     = current_slot_reg;
                            newest_sequence_next = tk_seq;
                        end
                        byte_position_next   = 8'd0;
                        running_crc_next     = CRC_INIT;
                        magic_match_next     = 1'b1;
                        header_version_next  = 16'd0;
                        header_sequence_next = 16'd0;
                        header_crc_next      = 16'd0;
                        header_length_next   = 16'd0;
                        current_slot_next    = cur_inc;
                    end
                    else
                    begin
                        byte_position_next   = tk_pos;
                        running_crc_next     = tk_run;
                        magic_match_next     = tk_magic;
                        header_version_next  = tk_ver;
                        header_sequence_next = tk_seq;
                        header_crc_next      = tk_crc;
                        header_length_next   = tk_len;
                    end
                end
                default:
                begin
                end
            endcase
        end

        res.slot_valid    = (res.reject_reason == RSN_OK);
        res.best_found    = have_best_next;
        res.best_slot     = newest_slot_next;
        res.best_sequence = newest_sequence_next;
        res.next_sequence = have_best_next ? newest_sequence_next + 16'd1 : 16'd1;
        if (!have_best_next || slot_count_reg == 8'd0)
            res.next_write_slot = 8'd0;
        else if (best_upd)
            res.next_write_slot = fresh_next_slot;
        else
            res.next_write_slot = next_slot_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg      <= RST_SLOT_COUNT;
            magic_word_reg      <= RST_MAGIC;
            format_version_reg  <= RST_VERSION;
            byte_position_reg   <= 8'd0;
            running_crc_reg     <= CRC_INIT;
            magic_match_reg     <= 1'b1;
            header_version_reg  <= 16'd0;
            header_sequence_reg <= 16'd0;
            header_crc_reg      <= 16'd0;
            header_length_reg   <= 16'd0;
            current_slot_reg    <= 8'd0;
            have_best_reg       <= 1'b0;
            newest_slot_reg     <= 8'd0;
            newest_sequence_reg <= 16'd0;
            rem_busy_reg        <= 1'b0;
            rem_step_reg        <= 3'd0;
            rem_acc_reg         <= 9'd0;
            rem_num_reg         <= 8'd0;
            next_slot_reg       <= 8'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SLOT_COUNT: slot_count_reg     <= cfg_data[7:0];
                    CFG_MAGIC:      magic_word_reg     <= cfg_data;
                    CFG_VERSION:    format_version_reg <= cfg_data[15:0];
                    default:
                    begin
                    end
                endcase
            end
            byte_position_reg   <= byte_position_next;
            running_crc_reg     <= running_crc_next;
            magic_match_reg     <= magic_match_next;
            header_version_reg  <= header_version_next;
            header_sequence_reg <= header_sequence_next;
            header_crc_reg      <= header_crc_next;
            header_length_reg   <= header_length_next;
            current_slot_reg    <= current_slot_next;
            have_best_reg       <= have_best_next;
            newest_slot_reg     <= newest_slot_next;
            newest_sequence_reg <= newest_sequence_next;
            rem_busy_reg        <= rem_busy_next;
            rem_step_reg        <= rem_step_next;
            rem_acc_reg         <= rem_acc_next;
            rem_num_reg         <= rem_num_next;
            next_slot_reg       <= next_slot_next;
        end
    end

    `NVM_SVI_ASSERT_NEXT(a_scan_clears, go && item.cmd == CMD_SCAN, !have_best_reg && current_slot_reg == 8'd0 && byte_position_reg == 8'd0, "scan did not clear state")
    `NVM_SVI_ASSERT(a_no_best_zero, !have_best_reg |-> (newest_sequence_reg == 16'd0 && newest_slot_reg == 8'd0), "best fields set without a best")
    `NVM_SVI_ASSERT_NEXT(a_valid_sets_best, res_fire && res.slot_valid, have_best_reg, "valid slot left no best")
    `NVM_SVI_ASSERT_NEXT(a_end_rewinds, res_fire, byte_position_reg == 8'd0 && running_crc_reg == CRC_INIT, "slot end did not rewind")
    `NVM_SVI_ASSERT(a_busy_blocks, !(go && rem_busy_reg), "word taken during remainder")

endmodule

>>> hdl/nvm_svi_out_stage.sv
`timescale 1ns / 1ps

module nvm_svi_out_stage
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  nvm_svi_pkg::result_t  res,
    output logic                  out_valid,
    input  logic                  out_ready,
    output nvm_svi_pkg::result_t  out_res
);
    import nvm_svi_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

endmodule

>>> hdl/nvm_slot_image_validator_core.sv
// slot image validator
// input stream carries one word per slot byte or command: tuser selects a
// slot byte, an unreadable slot or the start of a new scan, tdata holds the
// byte and tlast marks the final byte of a slot image
// the output stream gives one word per finished slot with its verdict, the
// best slot of the scan so far and the next slot and sequence to write
// one word is taken per cycle while the output is not stalled and no
// slot_count remainder is running; a result goes through the input register,
// then the result register; header capture, payload crc and all checks are
// done combinationally between the two registers
// when the output is stalled the result register holds and input words keep
// being accepted until the input register is full as well
// configuration is written through cfg_we / cfg_index / cfg_data while idle;
// a slot_count write holds the input register while the next write slot
// is recomputed one remainder bit per cycle
// reset clears both stream stages, sets slot_count 2, magic 0, version 3 and
// starts a fresh scan with no best slot
`timescale 1ns / 1ps

module nvm_slot_image_validator_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,   // last_in_slot
    input  logic [1:0]  s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // slot_index, slot_valid, reject_reason, slot_sequence, best_found,
    // best_slot, best_sequence, next_write_slot, next_sequence, zero pad
    output logic [79:0] m_axis_tdata
);
    import nvm_svi_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    take;
    logic    busy;
    logic    res_fire;
    result_t res;
    result_t out_res;

    assign in_item.cmd          = s_axis_tuser;
    assign in_item.data_byte    = s_axis_tdata;
    assign in_item.last_in_slot = s_axis_tlast;

    assign take = item_valid && !busy && (!m_axis_tvalid || m_axis_tready);

    nvm_svi_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    nvm_svi_check u_check
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .go        (take),
        .item      (item),
        .busy      (busy),
        .res_fire  (res_fire),
        .res       (res)
    );

    nvm_svi_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_fire),
        .res       (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata[7:0]   = out_res.slot_index;
    assign m_axis_tdata[8]     = out_res.slot_valid;
    assign m_axis_tdata[11:9]  = out_res.reject_reason;
    assign m_axis_tdata[27:12] = out_res.slot_sequence;
    assign m_axis_tdata[28]    = out_res.best_found;
    assign m_axis_tdata[36:29] = out_res.best_slot;
    assign m_axis_tdata[52:37] = out_res.best_sequence;
    assign m_axis_tdata[60:53] = out_res.next_write_slot;
    assign m_axis_tdata[76:61] = out_res.next_sequence;
    assign m_axis_tdata[79:77] = 3'd0;

endmodule

>>> tb/nvm_slot_image_validator_core_tb.sv
`timescale 1ns / 1ps

module nvm_slot_image_validator_core_tb;

    import nvm_svi_pkg::*;

    localparam logic [1:0] CMD_NONE    = 2'd3;
    localparam int         CYCLE_LIMIT = 600000;
    localparam int         PRINT_LIMIT = 40;

    typedef enum int {
        IMG_GOOD,
        IMG_BAD_MAGIC,
        IMG_BAD_VERSION,
        IMG_BAD_LENGTH,
        IMG_BAD_CRC,
        IMG_SHORT,
        IMG_LONG,
        IMG_UNREAD,
        IMG_NOISE
    } image_kind_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [1:0]  cfg_index     = 2'd0;
    logic [31:0] cfg_data      = 32'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic        s_axis_tlast  = 1'b0;
    logic [1:0]  s_axis_tuser  = 2'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;

    // register copies
    logic [7:0]  slots_cfg   = RST_SLOT_COUNT;
    logic [31:0] magic_cfg   = RST_MAGIC;
    logic [15:0] version_cfg = RST_VERSION;

    // scan state
    logic [7:0]  scan_pos     = 8'd0;
    logic [15:0] scan_crc     = CRC_INIT;
    logic        magic_ok     = 1'b1;
    logic [15:0] hdr_version  = 16'd0;
    logic [15:0] hdr_seq      = 16'd0;
    logic [15:0] hdr_crc      = 16'd0;
    logic [15:0] hdr_len      = 16'd0;
    logic [7:0]  slot_no      = 8'd0;
    logic        best_valid   = 1'b0;
    logic [7:0]  best_slot_no = 8'd0;
    logic [15:0] best_seq_no  = 16'd0;

    item_t       words_to_send[$];
    result_t     verdicts[$];
    item_t       next_word;
    result_t     got;
    result_t     want;

    int          n_queued     = 0;
    int          n_real       = 0;
    int          n_accepted   = 0;
    int          errors       = 0;
    int          cycle_count  = 0;
    int          send_gap_pct = 0;
    int          stall_pct    = 0;
    int          gen_slot     = 0;
    logic [15:0] seq_anchor   = 16'd0;

    nvm_slot_image_validator_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // bit-serial ccitt, msb first
    function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        int          i;
        r = c;
        for (i = 7; i >= 0; i--)
        begin
            fb = r[15] ^ b[i];
            r  = {r[14:0], 1'b0};
            if (fb)
                r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    function automatic logic seq_ahead(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] d;
        d = a - b;
        return (d != 16'd0) && !d[15];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] seen,
                                   input logic [31:0] wanted);
        if (errors < PRINT_LIMIT)
            $display("mismatch %s: got %0h expected %0h at %0t", what, seen, wanted, $realtime);
        errors++;
    endtask

    task automatic clear_slot_state();
        scan_pos    = 8'd0;
        scan_crc    = CRC_INIT;
        magic_ok    = 1'b1;
        hdr_version = 16'd0;
        hdr_seq     = 16'd0;
        hdr_crc     = 16'd0;
        hdr_len     = 16'd0;
    endtask

    task automatic post_verdict(input reason_t why, input logic [15:0] seq);
        result_t    r;
        logic [7:0] succ;
        succ              = best_slot_no + 8'd1;
        r.slot_index      = slot_no;
        r.slot_valid      = (why == RSN_OK);
        r.reject_reason   = why;
        r.slot_sequence   = seq;
        r.best_found      = best_valid;
        r.best_slot       = best_slot_no;
        r.best_sequence   = best_seq_no;
        r.next_write_slot = (best_valid && slots_cfg != 8'd0) ? succ % slots_cfg : 8'd0;
        r.next_sequence   = best_valid ? best_seq_no + 16'd1 : 16'd1;
        verdicts.push_back(r);
        if (slot_no != POS_MAX)
            slot_no = slot_no + 8'd1;
        clear_slot_state();
    endtask

    task automatic take_slot_byte(input logic [7:0] b);
        if (scan_pos < 8'd4)
        begin
            if (magic_cfg[8 * scan_pos +: 8] != b)
                magic_ok = 1'b0;
        end
        else if (scan_pos < 8'd6)
            hdr_version[8 * (scan_pos - 8'd4) +: 8] = b;
        else if (scan_pos < 8'd8)
            hdr_seq[8 * (scan_pos - 8'd6) +: 8] = b;
        else if (scan_pos < 8'd10)
            hdr_crc[8 * (scan_pos - 8'd8) +: 8] = b;
        else if (scan_pos < HDR_END)
            hdr_len[8 * (scan_pos - 8'd10) +: 8] = b;
        else if (scan_pos < SLOT_BYTES)
            scan_crc = crc_next(scan_crc, b);
        if (scan_pos != POS_MAX)
            scan_pos = scan_pos + 8'd1;
    endtask

    task automatic track_word(input logic [1:0] cmd, input logic [7:0] b, input logic last);
        reason_t why;
        case (cmd)
            CMD_SCAN:
            begin
                clear_slot_state();
                slot_no      = 8'd0;
                best_valid   = 1'b0;
                best_slot_no = 8'd0;
                best_seq_no  = 16'd0;
            end
            CMD_UNREAD:
            begin
                why = (slot_no >= slots_cfg) ? RSN_BEYOND : RSN_UNREADABLE;
                post_verdict(why, 16'd0);
            end
            CMD_BYTE:
            begin
                take_slot_byte(b);
                if (last)
                begin
                    if (slot_no >= slots_cfg)
                        why = RSN_BEYOND;
                    else if (!magic_ok)
                        why = RSN_MAGIC;
                    else if (hdr_version != version_cfg)
                        why = RSN_VERSION;
                    else if (hdr_len != PAYLOAD_LEN)
                        why = RSN_LENGTH;
                    else if (hdr_crc != scan_crc)
                        why = RSN_CRC;
                    else if (scan_pos != SLOT_BYTES)
                        why = RSN_COUNT;
                    else
                        why = RSN_OK;
                    if (why == RSN_OK && (!best_valid || seq_ahead(hdr_seq, best_seq_no)))
                    begin
                        best_valid   = 1'b1;
                        best_slot_no = slot_no;
                        best_seq_no  = hdr_seq;
                    end
                    post_verdict(why, hdr_seq);
                end
            end
            default: ;
        endcase
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                track_word(s_axis_tuser, s_axis_tdata, s_axis_tlast);
                n_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (words_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    next_word = words_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= next_word.cmd;
                    s_axis_tdata  <= next_word.data_byte;
                    s_axis_tlast  <= next_word.last_in_slot;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (verdicts.size() == 0)
                    report_mismatch("unexpected word", m_axis_tdata[31:0], 32'd0);
                else
                begin
                    want = verdicts.pop_front();
                    got  = result_t'(m_axis_tdata[76:0]);
                    if (got.slot_index !== want.slot_index)
                        report_mismatch("slot_index", got.slot_index, want.slot_index);
                    if (got.slot_valid !== want.slot_valid)
                        report_mismatch("slot_valid", got.slot_valid, want.slot_valid);
                    if (got.reject_reason !== want.reject_reason)
                        report_mismatch("reject_reason", got.reject_reason, want.reject_reason);
                    if (got.slot_sequence !== want.slot_sequence)
                        report_mismatch("slot_sequence", got.slot_sequence, want.slot_sequence);
                    if (got.best_found !== want.best_found)
                        report_mismatch("best_found", got.best_found, want.best_found);
                    if (got.best_slot !== want.best_slot)
                        report_mismatch("best_slot", got.best_slot, want.best_slot);
                    if (got.best_sequence !== want.best_sequence)
                        report_mismatch("best_sequence", got.best_sequence, want.best_sequence);
                    if (got.next_write_slot !== want.next_write_slot)
                        report_mismatch("next_write_slot", got.next_write_slot,
                                        want.next_write_slot);
                    if (got.next_sequence !== want.next_sequence)
                        report_mismatch("next_sequence", got.next_sequence, want.next_sequence);
                    if (m_axis_tdata[79:77] !== 3'd0)
                        report_mismatch("pad", m_axis_tdata[79:77], 32'd0);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic queue_word(input logic [1:0] cmd, input logic [7:0] b, input logic last);
        item_t w;
        w.cmd          = cmd;
        w.data_byte    = b;
        w.last_in_slot = last;
        words_to_send.push_back(w);
        n_queued++;
        if (cmd != CMD_NONE)
            n_real++;
    endtask

    // span: bytes kept for short and unread, extra bytes for long, length of noise
    task automatic queue_image(input image_kind_t kind, input logic [15:0] seq, input int span);
        logic [7:0]  img[$];
        logic [7:0]  pay[PAYLOAD_BYTES];
        logic [31:0] mag;
        logic [15:0] ver;
        logic [15:0] len;
        logic [15:0] pay_crc;
        int          k;
        mag     = magic_cfg;
        ver     = version_cfg;
        len     = PAYLOAD_LEN;
        pay_crc = CRC_INIT;
        for (k = 0; k < PAYLOAD_BYTES; k++)
        begin
            pay[k]  = 8'($urandom);
            pay_crc = crc_next(pay_crc, pay[k]);
        end
        case (kind)
            IMG_BAD_MAGIC:   mag     = mag ^ (32'd1 << $urandom_range(0, 31));
            IMG_BAD_VERSION: ver     = ver ^ 16'($urandom_range(1, 65535));
            IMG_BAD_LENGTH:  len     = len ^ 16'($urandom_range(1, 65535));
            IMG_BAD_CRC:     pay_crc = pay_crc ^ 16'($urandom_range(1, 65535));
            default: ;
        endcase
        for (k = 0; k < 4; k++)
            img.push_back(mag[8 * k +: 8]);
        img.push_back(ver[7:0]);
        img.push_back(ver[15:8]);
        img.push_back(seq[7:0]);
        img.push_back(seq[15:8]);
        img.push_back(pay_crc[7:0]);
        img.push_back(pay_crc[15:8]);
        img.push_back(len[7:0]);
        img.push_back(len[15:8]);
        for (k = 0; k < PAYLOAD_BYTES; k++)
            img.push_back(pay[k]);
        case (kind)
            IMG_SHORT, IMG_UNREAD:
                while (img.size() > span)
                    void'(img.pop_back());
            IMG_LONG:
                repeat (span) img.push_back(8'($urandom));
            IMG_NOISE:
            begin
                img.delete();
                repeat (span) img.push_back(8'($urandom));
            end
            default: ;
        endcase
        for (k = 0; k < img.size(); k++)
        begin
            if ($urandom_range(0, 24) == 0)
                queue_word(CMD_NONE, 8'($urandom), 1'($urandom));
            queue_word(CMD_BYTE, img[k], kind != IMG_UNREAD && k == img.size() - 1);
        end
        if (kind == IMG_UNREAD)
            queue_word(CMD_UNREAD, 8'($urandom), 1'($urandom));
    endtask

    function automatic logic [15:0] pick_seq();
        case ($urandom_range(0, 3))
            0:       return seq_anchor + 16'($urandom_range(0, 3));
            1:       return seq_anchor - 16'($urandom_range(0, 3));
            2:       return seq_anchor + SEQ_HALF - 16'($urandom_range(0, 1));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(input int min_words, input int min_slots);
        int          words0;
        int          slots_done;
        int          r;
        int          span;
        image_kind_t kind;
        words0     = n_real;
        slots_done = 0;
        while (n_real - words0 < min_words || slots_done < min_slots)
        begin
            if ((gen_slot >= slots_cfg && $urandom_range(0, 9) < 8) || $urandom_range(0, 49) == 0)
            begin
                queue_word(CMD_SCAN, 8'($urandom), 1'($urandom));
                gen_slot   = 0;
                seq_anchor = ($urandom_range(0, 3) == 0) ? 16'hFFFE : 16'($urandom);
            end
            r    = $urandom_range(0, 99);
            span = 0;
            if (r < 35)
                kind = IMG_GOOD;
            else if (r < 40)
                kind = IMG_BAD_MAGIC;
            else if (r < 45)
                kind = IMG_BAD_VERSION;
            else if (r < 50)
                kind = IMG_BAD_LENGTH;
            else if (r < 55)
                kind = IMG_BAD_CRC;
            else if (r < 70)
            begin
                kind = IMG_SHORT;
                span = $urandom_range(1, 131);
            end
            else if (r < 75)
            begin
                kind = IMG_LONG;
                span = $urandom_range(1, 150);
            end
            else if (r < 90)
            begin
                kind = IMG_UNREAD;
                span = $urandom_range(0, 20);
            end
            else
            begin
                kind = IMG_NOISE;
                span = $urandom_range(1, 16);
            end
            queue_image(kind, pick_seq(), span);
            gen_slot++;
            slots_done++;
        end
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (n_accepted != n_queued || verdicts.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_SLOT_COUNT: slots_cfg   = val[7:0];
            CFG_MAGIC:      magic_cfg   = val;
            CFG_VERSION:    version_cfg = val[15:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [7:0] slot_table[4];
        int         p;
        slot_table = '{8'd2, 8'd1, 8'd0, 8'd7};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // defaults after reset
        queue_word(CMD_NONE, 8'hFF, 1'b1);
        queue_image(IMG_GOOD, 16'hFFFF, 0);
        queue_image(IMG_GOOD, 16'h0000, 0);
        queue_word(CMD_UNREAD, 8'h00, 1'b0);
        queue_word(CMD_SCAN, 8'hFF, 1'b1);
        drain();

        write_reg(CFG_SLOT_COUNT, 32'd255);
        write_reg(CFG_MAGIC, 32'hFFFF_FFFF);
        write_reg(CFG_VERSION, 32'h0000_FFFF);
        queue_image(IMG_SHORT, 16'h0001, 12);
        queue_image(IMG_UNREAD, 16'h0003, 5);
        // run the slot index into saturation
        repeat (257) queue_word(CMD_UNREAD, 8'($urandom), 1'($urandom));
        queue_word(CMD_BYTE, 8'h00, 1'b1);
        queue_word(CMD_SCAN, 8'h00, 1'b0);
        drain();

        for (p = 0; p < 4; p++)
        begin
            case (p % 4)
                0:
                begin
                    send_gap_pct = 0;
                    stall_pct    = 0;
                end
                1:
                begin
                    send_gap_pct = 62;
                    stall_pct    = 0;
                end
                2:
                begin
                    send_gap_pct = 0;
                    stall_pct    = 62;
                end
                default:
                begin
                    send_gap_pct = 15;
                    stall_pct    = 15;
                end
            endcase
            write_reg(CFG_SLOT_COUNT, {24'd0, slot_table[p]});
            case (p % 3)
                0:       write_reg(CFG_MAGIC, 32'd0);
                1:       write_reg(CFG_MAGIC, 32'hFFFF_FFFF);
                default: write_reg(CFG_MAGIC, $urandom);
            endcase
            case ((p + 1) % 3)
                0:       write_reg(CFG_VERSION, 32'd0);
                1:       write_reg(CFG_VERSION, 32'h0000_FFFF);
                default: write_reg(CFG_VERSION, {16'd0, 16'($urandom)});
            endcase
            random_phase(90, 1);
            drain();
        end

        if (errors == 0 && verdicts.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/nvm_svi_pkg.sv
hdl/nvm_svi_in_stage.sv
hdl/nvm_svi_check.sv
hdl/nvm_svi_out_stage.sv
hdl/nvm_slot_image_validator_core.sv
tb/nvm_slot_image_validator_core_tb.sv
